### rtl/core/qet_pkg.sv
// shared types, constants and helpers for the quadratic escape time core
`default_nettype none

package qet_pkg;

    localparam int FRAC_BITS_DEF  = 24;
    localparam int COUNT_BITS_DEF = 16;
    localparam int RADIUS_SQ      = 100;
    localparam int CFG_ADDR_BITS  = 4;

    localparam logic [1:0] REG_START_RE   = 2'd0;
    localparam logic [1:0] REG_START_IM   = 2'd1;
    localparam logic [1:0] REG_ITER_LIMIT = 2'd2;

    localparam logic [15:0] ITER_LIMIT_RST = 16'd500;

    typedef struct packed {
        logic signed [31:0] point_re;
        logic signed [31:0] point_im;
    } t_in_item;

    typedef struct packed {
        logic [15:0] steps;
        logic        escaped;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] start_re;
        logic signed [31:0] start_im;
        logic [15:0]        iter_limit;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic mul;
        logic step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_EVAL,
        ST_HOLD
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (v > 65'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -65'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/qet_regs.sv
// configuration register file with apb-style access
`default_nettype none

module qet_regs
    import qet_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]              pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output t_cfg                          o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_re   <= '0;
            r_cfg.start_im   <= '0;
            r_cfg.iter_limit <= ITER_LIMIT_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_START_RE:   r_cfg.start_re   <= pwdata;
                REG_START_IM:   r_cfg.start_im   <= pwdata;
                REG_ITER_LIMIT: r_cfg.iter_limit <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_START_RE:   prdata = r_cfg.start_re;
            REG_START_IM:   prdata = r_cfg.start_im;
            REG_ITER_LIMIT: prdata = {16'b0, r_cfg.iter_limit};
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/qet_datapath.sv
// orbit registers, multipliers, escape compare and result register
`default_nettype none

module qet_datapath
    import qet_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire t_cmd     i_cmd,
    input  wire t_in_item i_in,
    input  wire t_cfg     i_cfg,
    output t_status       o_status,
    output t_out_item     o_out
);

    localparam logic [63:0] ESC_THRESH = 64'(RADIUS_SQ) << (2 * FRAC_BITS);

    logic signed [31:0]    r_re, r_im, r_cre, r_cim;
    logic signed [63:0]    r_re2, r_im2, r_reim;
    logic [COUNT_BITS-1:0] r_cnt;
    t_out_item             r_out;

    logic [COUNT_BITS+15:0] w_lim_ext, w_cnt_ext;
    logic [COUNT_BITS-1:0]  w_limit;
    logic [63:0]            w_mag;
    logic signed [63:0]     w_diff;
    logic signed [64:0]     w_nre_sum, w_nim_sum;
    logic                   w_limit_hit, w_escape;
    t_out_item              w_res;

    assign w_lim_ext   = {{COUNT_BITS{1'b0}}, i_cfg.iter_limit};
    assign w_limit     = w_lim_ext[COUNT_BITS-1:0];
    assign w_cnt_ext   = {16'b0, r_cnt};
    assign w_limit_hit = r_cnt >= w_limit;
    assign w_mag       = $unsigned(r_re2) + $unsigned(r_im2);
    assign w_escape    = w_mag >= ESC_THRESH;
    assign w_diff      = r_re2 - r_im2;
    assign w_nre_sum   = 65'(w_diff >>> FRAC_BITS) + 65'(r_cre);
    assign w_nim_sum   = 65'(r_reim >>> (FRAC_BITS - 1)) + 65'(r_cim);

    assign o_status.done = w_limit_hit | w_escape;

    always_comb begin
        w_res.escaped = ~w_limit_hit;
        w_res.steps   = w_limit_hit ? 16'd0 : w_cnt_ext[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_re  <= i_cfg.start_re;
            r_im  <= i_cfg.start_im;
            r_cre <= i_in.point_re;
            r_cim <= i_in.point_im;
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_re  <= sat32(w_nre_sum);
            r_im  <= sat32(w_nim_sum);
            r_cnt <= r_cnt + COUNT_BITS'(1);
        end
        if (i_cmd.mul) begin
            r_re2  <= 64'(r_re) * 64'(r_re);
            r_im2  <= 64'(r_im) * 64'(r_im);
            r_reim <= 64'(r_re) * 64'(r_im);
        end
        if (i_cmd.load_out) begin
            r_out <= w_res;
        end
    end

    assign o_out = r_out;

endmodule

`default_nettype wire

### rtl/core/qet_ctrl.sv
// iteration sequencer and output handshake control
`default_nettype none

module qet_ctrl
    import qet_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free  = ~r_out_valid | ~i_out_stall;
    assign o_in_stall  = r_state != ST_IDLE;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_EVAL;
            end
            ST_EVAL: begin
                if (!i_status.done) begin
                    o_cmd.step = 1'b1;
                    n_state    = ST_MUL;
                end else if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

endmodule

`default_nettype wire

### rtl/core/quadratic_escape_time_core.sv
// top level of the quadratic map escape time core
//
// channel   direction  payload      handshake
// in        input      t_in_item    i_in_valid / o_in_stall
// out       output     t_out_item   o_out_valid / i_out_stall
// cfg       input      32-bit regs  psel / penable / pwrite / pready
//
// a point steps the map until escape or limit, each step being a multiply
// state and a compare/update state through the shared three-multiplier datapath
// the next point is taken only in the idle state after its result is loaded,
// so none is taken while one is in flight; a full output register holds it off
// reset clears the sequencer and output valid and presets the config registers
`default_nettype none

module quadratic_escape_time_core
    import qet_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire t_in_item                 i_in_data,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output t_out_item                     o_out_data,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]              pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    t_cfg    w_cfg;
    t_cmd    w_cmd;
    t_status w_status;

    qet_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    qet_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    qet_datapath #(
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_cmd    (w_cmd),
        .i_in     (i_in_data),
        .i_cfg    (w_cfg),
        .o_status (w_status),
        .o_out    (o_out_data)
    );

endmodule

`default_nettype wire

### sim/tb_top.sv
// self-checking testbench for the quadratic escape time core: random and directed points
`default_nettype none

module tb_top;
    import qet_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam logic [CFG_ADDR_BITS-1:0] ADDR_START_RE   = {REG_START_RE, 2'b00};
    localparam logic [CFG_ADDR_BITS-1:0] ADDR_START_IM   = {REG_START_IM, 2'b00};
    localparam logic [CFG_ADDR_BITS-1:0] ADDR_ITER_LIMIT = {REG_ITER_LIMIT, 2'b00};
    localparam logic [CFG_ADDR_BITS-1:0] ADDR_UNMAPPED   = 4'hc;
    localparam longint unsigned ESC_THRESH = 64'(RADIUS_SQ) << (2 * FRAC);
    localparam longint WORD_HI = 64'sd2147483647;
    localparam longint WORD_LO = -64'sd2147483648;
    localparam logic [31:0] ONE     = 32'h0100_0000;
    localparam logic [31:0] MAX_VAL = 32'h7fff_ffff;
    localparam logic [31:0] MIN_VAL = 32'h8000_0000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 150;
    localparam int TAIL_CYCLES = 40;
    localparam int IDLE_LIMIT  = 400000;
    localparam int MAX_REPORTS = 50;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    in_data = '0;
    logic        o_out_valid;
    logic        out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    t_in_item    point_q[$];
    t_out_item   predicted_q[$];
    t_out_item   want;
    t_cfg        model_cfg = '{start_re: '0, start_im: '0, iter_limit: ITER_LIMIT_RST};
    int          err_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int unsigned rx_cycle = 0;
    int          hold_left = 0;
    int          stall_mode = 0;
    int          idle_cycles = 0;

    quadratic_escape_time_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #2 i_clk = ~i_clk;

    function automatic longint clip_word(input longint v);
        if (v > WORD_HI) begin
            return WORD_HI;
        end else if (v < WORD_LO) begin
            return WORD_LO;
        end
        return v;
    endfunction

    function automatic t_out_item escape_time(input t_in_item pt, input t_cfg cfg);
        longint re, im, cre, cim, prod, diff, nre, nim;
        longint unsigned ar, ai, re2, im2;
        int unsigned n;
        logic done;
        t_out_item res;
        re = $signed(cfg.start_re);
        im = $signed(cfg.start_im);
        cre = $signed(pt.point_re);
        cim = $signed(pt.point_im);
        n = 0;
        done = 1'b0;
        while (!done) begin
            ar = (re < 0) ? -re : re;
            ai = (im < 0) ? -im : im;
            re2 = ar * ar;
            im2 = ai * ai;
            if (n >= cfg.iter_limit || re2 + im2 >= ESC_THRESH) begin
                done = 1'b1;
            end else begin
                prod = re * im;
                diff = longint'(re2) - longint'(im2);
                nim = clip_word((prod >>> (FRAC - 1)) + cim);
                nre = clip_word((diff >>> FRAC) + cre);
                re = nre;
                im = nim;
                n++;
            end
        end
        if (n < cfg.iter_limit) begin
            res.steps = n[15:0];
            res.escaped = 1'b1;
        end else begin
            res.steps = '0;
            res.escaped = 1'b0;
        end
        return res;
    endfunction

    function automatic t_in_item mk_point(input logic [31:0] re, input logic [31:0] im);
        t_in_item p;
        p.point_re = re;
        p.point_im = im;
        return p;
    endfunction

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return MAX_VAL;
            1: return MIN_VAL;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            4: return 32'h1;
            default: return 32'h0a00_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_start();
        case ($urandom_range(0, 5))
            0, 1, 2: return 32'h0;
            3: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
            4: return $urandom();
            default: return pick_extreme();
        endcase
    endfunction

    function automatic t_in_item rand_point();
        t_in_item p;
        case ($urandom_range(0, 9))
            6: begin
                p.point_re = $urandom();
                p.point_im = $urandom();
            end
            7: begin
                p.point_re = pick_extreme();
                p.point_im = pick_extreme();
            end
            8, 9: begin
                p.point_re = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
                p.point_im = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
            end
            default: begin
                p.point_re = $urandom_range(0, 32'h0400_0000) - 32'h0280_0000;
                p.point_im = $urandom_range(0, 32'h0300_0000) - 32'h0180_0000;
            end
        endcase
        return p;
    endfunction

    task automatic report_mismatch(input string what, input int exp_val, input int got_val);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("%0t %s mismatch: expected %0d actual %0d", $time, what, exp_val, got_val);
        end
    endtask

    task automatic reg_write(input logic [CFG_ADDR_BITS-1:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (addr)
            ADDR_START_RE:   model_cfg.start_re = data;
            ADDR_START_IM:   model_cfg.start_im = data;
            ADDR_ITER_LIMIT: model_cfg.iter_limit = data[15:0];
            default: ;
        endcase
    endtask

    task automatic set_cfg(input logic [31:0] re, input logic [31:0] im, input logic [15:0] lim);
        reg_write(ADDR_START_RE, re);
        reg_write(ADDR_ITER_LIMIT, {16'($urandom_range(0, 16'hffff)), lim});
        reg_write(ADDR_UNMAPPED, $urandom());
        reg_write(ADDR_START_IM, im);
        @(negedge i_clk);
    endtask

    task automatic drain();
        do begin
            @(negedge i_clk);
        end while (point_q.size() != 0 || in_valid || predicted_q.size() != 0);
    endtask

    // sender: bursts with random gaps, payload held while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                predicted_q.push_back(escape_time(in_data, model_cfg));
            end
            if (!(in_valid && o_in_stall)) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (point_q.size() != 0) begin
                    in_data <= point_q.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left != 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each transfer, stalls on its own pattern with periodic long holds
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (predicted_q.size() == 0) begin
                    report_mismatch("unexpected result, steps", -1, o_out_data.steps);
                end else begin
                    want = predicted_q.pop_front();
                    if (o_out_data.steps !== want.steps) begin
                        report_mismatch("steps", want.steps, o_out_data.steps);
                    end
                    if (o_out_data.escaped !== want.escaped) begin
                        report_mismatch("escaped", want.escaped, o_out_data.escaped);
                    end
                end
            end
            if (hold_left == 0 && rx_cycle % 20000 == 10000) begin
                hold_left = 600;
            end
            if (rx_cycle[6:0] == 0) begin
                stall_mode = $urandom_range(0, 3);
            end
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 7) == 0);
                    2: out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= ($urandom_range(0, 7) != 0);
                endcase
            end
            rx_cycle++;
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [15:0] lim;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: start at zero, limit 500
        point_q.push_back(mk_point(32'h0, 32'h0));
        point_q.push_back(mk_point(MAX_VAL, MAX_VAL));
        point_q.push_back(mk_point(MIN_VAL, MIN_VAL));
        point_q.push_back(mk_point(MAX_VAL, MIN_VAL));
        point_q.push_back(mk_point(MIN_VAL, MAX_VAL));
        point_q.push_back(mk_point(-(2 * ONE), 32'h0));
        point_q.push_back(mk_point(ONE >> 2, 32'h0));
        point_q.push_back(mk_point(32'h0, ONE));
        point_q.push_back(mk_point(2 * ONE, 32'h0));
        point_q.push_back(mk_point(-ONE, 32'h0));
        point_q.push_back(mk_point(10 * ONE, 32'h0));
        point_q.push_back(mk_point(10 * ONE - 1, 32'h0));
        point_q.push_back(mk_point(6 * ONE, 8 * ONE));
        point_q.push_back(mk_point(32'hffff_ffff, 32'hffff_ffff));
        point_q.push_back(mk_point(32'h0, -ONE));
        drain();

        // zero limit
        set_cfg(32'h0, 32'h0, 16'd0);
        point_q.push_back(mk_point(32'h0, 32'h0));
        point_q.push_back(mk_point(MAX_VAL, MAX_VAL));
        drain();

        // start on or outside the radius
        set_cfg(10 * ONE, 32'h0, 16'd5);
        point_q.push_back(mk_point(32'h0, 32'h0));
        point_q.push_back(mk_point(MIN_VAL, 32'h0));
        drain();
        set_cfg(MIN_VAL, MAX_VAL, 16'hffff);
        point_q.push_back(mk_point(32'h0, 32'h0));
        drain();

        // escape on the last allowed step still counts as bounded
        set_cfg(32'h0, 32'h0, 16'd1);
        point_q.push_back(mk_point(MAX_VAL, MAX_VAL));
        point_q.push_back(mk_point(32'h0, 32'h0));
        drain();

        // widest limit, one bounded point
        set_cfg(32'h0, 32'h0, 16'hffff);
        point_q.push_back(mk_point(32'h0, 32'h0));
        point_q.push_back(mk_point(MAX_VAL, 32'h0));
        drain();

        set_cfg(ONE >> 1, -(ONE >> 1), 16'd3);
        repeat (3) point_q.push_back(rand_point());

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain();
            case (ph % 4)
                0: lim = 16'($urandom_range(1, 8));
                1: lim = 16'($urandom_range(9, 64));
                2: lim = 16'($urandom_range(65, 300));
                default: lim = 16'($urandom_range(0, 3));
            endcase
            set_cfg(rand_start(), rand_start(), lim);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                point_q.push_back(rand_point());
            end
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (predicted_q.size() != 0) begin
            report_mismatch("results left over", 0, predicted_q.size());
        end
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

### quadratic_escape_time_core.f
rtl/core/qet_pkg.sv
rtl/core/qet_regs.sv
rtl/core/qet_datapath.sv
rtl/core/qet_ctrl.sv
rtl/core/quadratic_escape_time_core.sv
sim/tb_top.sv
